// ----- rtl/core/mqll_pkg.sv -----
// shared opcodes, result codes and types of the multi-queue linked list manager
`default_nettype none

package mqll_pkg;

   typedef logic [1:0] mqll_op_type;
   typedef logic [1:0] mqll_code_type;

   // operation codes of an input word
   localparam mqll_op_type OP_ENQUEUE = 2'd0;
   localparam mqll_op_type OP_DEQUEUE = 2'd1;
   localparam mqll_op_type OP_REMOVE  = 2'd2;

   // result codes
   localparam mqll_code_type RC_DONE   = 2'd0;
   localparam mqll_code_type RC_EMPTY  = 2'd1;
   localparam mqll_code_type RC_ABSENT = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/mqll_ram.sv -----
// single-port-write, single-port-read synchronous ram with a registered read port
`default_nettype none

module mqll_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/mqll_seq.sv -----
// sequencer: read-modify-write of the queue table and link table, list walk, clearing pass
`default_nettype none

module mqll_seq #(
   parameter int NUM_THREADS = 64,
   parameter int NUM_QUEUES = 65,
   localparam int IW = $clog2(NUM_THREADS + 1),
   localparam int TW = $clog2(NUM_THREADS),
   localparam int QW = $clog2(NUM_QUEUES + 1),
   localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mqll_pkg::mqll_op_type  req_opcode,
   input  wire logic [QW-1:0]          req_queue_id,
   input  wire logic [TW-1:0]          req_thread_id,
   // result handoff to the output register
   input  wire logic                   slot_free,
   output logic                        res_valid,
   output logic [IW-1:0]               res_popped,
   output mqll_pkg::mqll_code_type     res_code,
   // queue table port
   output logic                        q_rd_en,
   output logic [QAW-1:0]              q_rd_addr,
   input  wire logic [2*IW-1:0]        q_rd_data,
   output logic                        q_wr_en,
   output logic [QAW-1:0]              q_wr_addr,
   output logic [2*IW-1:0]             q_wr_data,
   // link table port
   output logic                        l_rd_en,
   output logic [TW-1:0]               l_rd_addr,
   input  wire logic [2*IW-1:0]        l_rd_data,
   output logic                        l_wr_en,
   output logic [TW-1:0]               l_wr_addr,
   output logic [2*IW-1:0]             l_wr_data
);

   import mqll_pkg::*;

   localparam int MAXD = (NUM_QUEUES > NUM_THREADS) ? NUM_QUEUES : NUM_THREADS;
   localparam int CW = $clog2(MAXD);
   localparam logic [CW-1:0] LAST_CLR = CW'(MAXD - 1);
   localparam logic [IW-1:0] NONE = IW'(NUM_THREADS);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_QRD,
      S_ENQ_LAST,
      S_ENQ_SELF,
      S_DEQ_HEAD,
      S_DEQ_NH,
      S_WALK,
      S_REM_T,
      S_REM_NX,
      S_REM_PV_RD,
      S_REM_PV,
      S_CLR_T,
      S_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  clr_ff, clr_in;
   mqll_op_type    op_ff, op_in;
   logic [QW-1:0]  q_ff, q_in;
   logic [TW-1:0]  t_ff, t_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [IW-1:0]  link_a_ff, link_a_in;
   logic [IW-1:0]  link_b_ff, link_b_in;
   logic [IW-1:0]  steps_ff, steps_in;
   logic [IW-1:0]  popped_ff, popped_in;
   mqll_code_type  code_ff, code_in;

   logic [IW-1:0]  qh, qt, ln, lp, t_ext, p;
   logic           qok, tok, accept;

   // field views of the table words
   assign qh = q_rd_data[2*IW-1:IW];
   assign qt = q_rd_data[IW-1:0];
   assign ln = l_rd_data[2*IW-1:IW];
   assign lp = l_rd_data[IW-1:0];
   assign t_ext = IW'(t_ff);

   assign qok = int'(req_queue_id) < NUM_QUEUES;
   assign tok = int'(req_thread_id) < NUM_THREADS;

   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && slot_free);
   assign accept = req_valid && req_ready;

   assign res_popped = popped_ff;
   assign res_code = code_ff;

   // next state and table accesses
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      q_in = q_ff;
      t_in = t_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      link_a_in = link_a_ff;
      link_b_in = link_b_ff;
      steps_in = steps_ff;
      popped_in = popped_ff;
      code_in = code_ff;
      p = qh;
      res_valid = 1'b0;
      q_rd_en = 1'b0;
      q_rd_addr = req_queue_id[QAW-1:0];
      q_wr_en = 1'b0;
      q_wr_addr = q_ff[QAW-1:0];
      q_wr_data = {NONE, NONE};
      l_rd_en = 1'b0;
      l_rd_addr = t_ff;
      l_wr_en = 1'b0;
      l_wr_addr = t_ff;
      l_wr_data = {NONE, NONE};

      case (state_ff)
         // clearing pass after reset, one entry of each table a cycle
         S_CLEAR: begin
            q_wr_en = int'(clr_ff) < NUM_QUEUES;
            q_wr_addr = clr_ff[QAW-1:0];
            l_wr_en = int'(clr_ff) < NUM_THREADS;
            l_wr_addr = clr_ff[TW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_CLR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
         end

         // queue word arrived: head and tail of the addressed queue
         S_QRD: begin
            head_in = qh;
            tail_in = qt;
            q_wr_addr = q_ff[QAW-1:0];
            case (op_ff)
               OP_ENQUEUE: begin
                  q_wr_en = 1'b1;
                  if (qh == NONE) begin
                     q_wr_data = {t_ext, t_ext};
                     l_wr_en = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     q_wr_data = {qh, t_ext};
                     link_a_in = qt;
                     if (qt != NONE) begin
                        l_rd_en = 1'b1;
                        l_rd_addr = qt[TW-1:0];
                        state_in = S_ENQ_LAST;
                     end else begin
                        state_in = S_ENQ_SELF;
                     end
                  end
               end
               OP_DEQUEUE: begin
                  if (qh == NONE) begin
                     code_in = RC_EMPTY;
                     state_in = S_DONE;
                  end else if (qt != qh) begin
                     popped_in = qh;
                     l_rd_en = 1'b1;
                     l_rd_addr = qh[TW-1:0];
                     state_in = S_DEQ_HEAD;
                  end else begin
                     // single element: queue goes empty, popped links cleared
                     popped_in = qh;
                     q_wr_en = 1'b1;
                     l_wr_en = 1'b1;
                     l_wr_addr = qh[TW-1:0];
                     state_in = S_DONE;
                  end
               end
               default: begin
                  // remove: start the walk at the head
                  steps_in = IW'(1);
                  if ((qh != NONE) && (qh != t_ext)) begin
                     l_rd_en = 1'b1;
                     l_rd_addr = qh[TW-1:0];
                     state_in = S_WALK;
                  end else if (qh == t_ext) begin
                     l_rd_en = 1'b1;
                     state_in = S_REM_T;
                  end else begin
                     code_in = RC_ABSENT;
                     state_in = S_DONE;
                  end
               end
            endcase
         end

         // old tail gets its next link pointed at the new thread
         S_ENQ_LAST: begin
            l_wr_en = 1'b1;
            l_wr_addr = link_a_ff[TW-1:0];
            l_wr_data = {t_ext, lp};
            state_in = S_ENQ_SELF;
         end

         S_ENQ_SELF: begin
            l_wr_en = 1'b1;
            l_wr_data = {NONE, link_a_ff};
            state_in = S_DONE;
         end

         // new head is the old head's next link
         S_DEQ_HEAD: begin
            q_wr_en = 1'b1;
            q_wr_data = {ln, tail_ff};
            link_a_in = ln;
            if (ln != NONE) begin
               l_rd_en = 1'b1;
               l_rd_addr = ln[TW-1:0];
               state_in = S_DEQ_NH;
            end else begin
               state_in = S_CLR_T;
            end
         end

         S_DEQ_NH: begin
            l_wr_en = 1'b1;
            l_wr_addr = link_a_ff[TW-1:0];
            l_wr_data = {ln, NONE};
            state_in = S_CLR_T;
         end

         // one link a cycle, bounded by the thread count
         S_WALK: begin
            p = ln;
            if ((p != NONE) && (p != t_ext) && (steps_ff < NONE)) begin
               l_rd_en = 1'b1;
               l_rd_addr = p[TW-1:0];
               steps_in = steps_ff + 1'b1;
            end else if (p == t_ext) begin
               l_rd_en = 1'b1;
               state_in = S_REM_T;
            end else begin
               code_in = RC_ABSENT;
               state_in = S_DONE;
            end
         end

         // found thread: patch head and tail, then neighbor links
         S_REM_T: begin
            link_a_in = ln;
            link_b_in = lp;
            q_wr_en = 1'b1;
            q_wr_data = {(lp == NONE) ? ln : head_ff, (ln == NONE) ? lp : tail_ff};
            if (ln != NONE) begin
               l_rd_en = 1'b1;
               l_rd_addr = ln[TW-1:0];
               state_in = S_REM_NX;
            end else if (lp != NONE) begin
               l_rd_en = 1'b1;
               l_rd_addr = lp[TW-1:0];
               state_in = S_REM_PV;
            end else begin
               state_in = S_CLR_T;
            end
         end

         S_REM_NX: begin
            l_wr_en = 1'b1;
            l_wr_addr = link_a_ff[TW-1:0];
            l_wr_data = {ln, link_b_ff};
            if (link_b_ff != NONE) begin
               state_in = S_REM_PV_RD;
            end else begin
               state_in = S_CLR_T;
            end
         end

         // read after the write above has landed
         S_REM_PV_RD: begin
            l_rd_en = 1'b1;
            l_rd_addr = link_b_ff[TW-1:0];
            state_in = S_REM_PV;
         end

         S_REM_PV: begin
            l_wr_en = 1'b1;
            l_wr_addr = link_b_ff[TW-1:0];
            l_wr_data = {link_a_ff, lp};
            state_in = S_CLR_T;
         end

         // clear both links of the popped or removed thread
         S_CLR_T: begin
            l_wr_en = 1'b1;
            l_wr_addr = (op_ff == OP_DEQUEUE) ? head_ff[TW-1:0] : t_ff;
            state_in = S_DONE;
         end

         // hand the result word to the output register
         S_DONE: begin
            if (slot_free) begin
               res_valid = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // take a new request word and fetch its queue entry
      if (accept) begin
         op_in = req_opcode;
         q_in = req_queue_id;
         t_in = req_thread_id;
         popped_in = NONE;
         code_in = RC_DONE;
         if (((req_opcode == OP_ENQUEUE) && qok && tok) ||
             ((req_opcode == OP_DEQUEUE) && qok) ||
             ((req_opcode == OP_REMOVE) && qok && tok)) begin
            q_rd_en = 1'b1;
            state_in = S_QRD;
         end else begin
            if (req_opcode == OP_DEQUEUE) begin
               code_in = RC_EMPTY;
            end else if (req_opcode == OP_REMOVE) begin
               code_in = RC_ABSENT;
            end
            state_in = S_DONE;
         end
      end
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
      op_ff <= op_in;
      q_ff <= q_in;
      t_ff <= t_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      link_a_ff <= link_a_in;
      link_b_ff <= link_b_in;
      steps_ff <= steps_in;
      popped_ff <= popped_in;
      code_ff <= code_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/multi_queue_linked_list_manager_unit.sv -----
// Enqueue, dequeue and remove each run through their own sequence of states per word; remove
// also walks the list from the head, bounded by NUM_THREADS links; an out-of-range id or an
// unused opcode goes straight to the result. Each table access is a read-modify-write through
// a ram port with a registered read, and the link table's single read and write ports
// serialize the link accesses. A new word is taken while a result waits in the output register.
// Reset starts a clearing pass over max(NUM_QUEUES, NUM_THREADS) entries, req_ready low.
`default_nettype none

module multi_queue_linked_list_manager_unit #(
   parameter int NUM_THREADS = 64,
   parameter int NUM_QUEUES = 65,
   localparam int IW = $clog2(NUM_THREADS + 1),
   localparam int TW = $clog2(NUM_THREADS),
   localparam int QW = $clog2(NUM_QUEUES + 1),
   localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire mqll_pkg::mqll_op_type  req_opcode,
   input  wire logic [QW-1:0]          req_queue_id,
   input  wire logic [TW-1:0]          req_thread_id,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [IW-1:0]               rsp_popped_id,
   output mqll_pkg::mqll_code_type     rsp_result_code
);

   import mqll_pkg::*;

   logic               slot_free;
   logic               res_valid;
   logic [IW-1:0]      res_popped;
   mqll_code_type      res_code;

   logic               q_rd_en, q_wr_en;
   logic [QAW-1:0]     q_rd_addr, q_wr_addr;
   logic [2*IW-1:0]    q_rd_data, q_wr_data;
   logic               l_rd_en, l_wr_en;
   logic [TW-1:0]      l_rd_addr, l_wr_addr;
   logic [2*IW-1:0]    l_rd_data, l_wr_data;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]      rsp_popped_ff;
   mqll_code_type      rsp_code_ff;

   // queue table: {head, tail} per queue
   mqll_ram #(
      .WIDTH (2 * IW),
      .DEPTH (NUM_QUEUES)
   ) u_qtab (
      .clock      (clock),
      .rd_en      (q_rd_en),
      .rd_addr    (q_rd_addr),
      .rd_data_ff (q_rd_data),
      .wr_en      (q_wr_en),
      .wr_addr    (q_wr_addr),
      .wr_data    (q_wr_data)
   );

   // link table: {next, prev} per thread
   mqll_ram #(
      .WIDTH (2 * IW),
      .DEPTH (NUM_THREADS)
   ) u_ltab (
      .clock      (clock),
      .rd_en      (l_rd_en),
      .rd_addr    (l_rd_addr),
      .rd_data_ff (l_rd_data),
      .wr_en      (l_wr_en),
      .wr_addr    (l_wr_addr),
      .wr_data    (l_wr_data)
   );

   mqll_seq #(
      .NUM_THREADS (NUM_THREADS),
      .NUM_QUEUES  (NUM_QUEUES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_queue_id  (req_queue_id),
      .req_thread_id (req_thread_id),
      .slot_free     (slot_free),
      .res_valid     (res_valid),
      .res_popped    (res_popped),
      .res_code      (res_code),
      .q_rd_en       (q_rd_en),
      .q_rd_addr     (q_rd_addr),
      .q_rd_data     (q_rd_data),
      .q_wr_en       (q_wr_en),
      .q_wr_addr     (q_wr_addr),
      .q_wr_data     (q_wr_data),
      .l_rd_en       (l_rd_en),
      .l_rd_addr     (l_rd_addr),
      .l_rd_data     (l_rd_data),
      .l_wr_en       (l_wr_en),
      .l_wr_addr     (l_wr_addr),
      .l_wr_data     (l_wr_data)
   );

   // output register holds one result word
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_popped_ff <= res_popped;
         rsp_code_ff <= res_code;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_popped_id = rsp_popped_ff;
   assign rsp_result_code = rsp_code_ff;

endmodule

`default_nettype wire

// ----- tb/sv/multi_queue_linked_list_manager_unit_tb.sv -----
// testbench of the multi-queue linked list manager: directed and random words, scoreboard check
`timescale 1ns / 1ps

module multi_queue_linked_list_manager_unit_tb;

   import mqll_pkg::*;

   localparam int NUM_THREADS = 64;
   localparam int NUM_QUEUES  = 65;
   localparam int IW = 7;
   localparam int TW = 6;
   localparam int QW = 7;
   localparam logic [IW-1:0] NONE = IW'(NUM_THREADS);
   localparam mqll_op_type OP_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 1000;
   localparam int CALM_WORDS   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [IW-1:0] popped;
      mqll_code_type code;
   } outcome_type;

   // shadow of the queue tables and the outcomes still owed by the block
   class linked_queue_checker;
      logic [IW-1:0] head [NUM_QUEUES];
      logic [IW-1:0] tail [NUM_QUEUES];
      logic [IW-1:0] nxt [NUM_THREADS];
      logic [IW-1:0] prv [NUM_THREADS];
      int owner [NUM_THREADS];
      outcome_type pending_outcomes [$];
      int mismatches;
      int results_seen;
      int pops;
      int code_hits [4];

      function new();
         foreach (head[i]) begin
            head[i] = NONE;
            tail[i] = NONE;
         end
         foreach (nxt[i]) begin
            nxt[i] = NONE;
            prv[i] = NONE;
            owner[i] = -1;
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("tb: mismatch: %s", msg);
      endtask

      // link accessors: NONE is never used as a table index
      function void put_nxt(logic [IW-1:0] t, logic [IW-1:0] v);
         if (t < NUM_THREADS) nxt[t] = v;
      endfunction

      function void put_prv(logic [IW-1:0] t, logic [IW-1:0] v);
         if (t < NUM_THREADS) prv[t] = v;
      endfunction

      function logic [IW-1:0] get_nxt(logic [IW-1:0] t);
         return (t < NUM_THREADS) ? nxt[t] : NONE;
      endfunction

      function logic [IW-1:0] get_prv(logic [IW-1:0] t);
         return (t < NUM_THREADS) ? prv[t] : NONE;
      endfunction

      function void link_append(int q, logic [IW-1:0] t);
         logic [IW-1:0] last;
         if (head[q] == NONE) begin
            head[q] = t;
            put_prv(t, NONE);
         end else begin
            last = tail[q];
            put_nxt(last, t);
            put_prv(t, last);
         end
         put_nxt(t, NONE);
         tail[q] = t;
      endfunction

      function logic [IW-1:0] pop_head(int q);
         logic [IW-1:0] h;
         logic [IW-1:0] nh;
         h = head[q];
         if (h == NONE) return NONE;
         if (tail[q] != h) begin
            nh = get_nxt(h);
            head[q] = nh;
            put_prv(nh, NONE);
         end else begin
            head[q] = NONE;
            tail[q] = NONE;
         end
         put_nxt(h, NONE);
         put_prv(h, NONE);
         return h;
      endfunction

      // walk from the head, bounded so a corrupted list cannot loop forever
      function bit unlink(int q, logic [IW-1:0] t);
         logic [IW-1:0] p;
         logic [IW-1:0] nx;
         logic [IW-1:0] pv;
         int steps;
         p = head[q];
         steps = 0;
         while (p != NONE && p != t && steps < NUM_THREADS) begin
            p = get_nxt(p);
            steps++;
         end
         if (p != t) return 1'b0;
         nx = get_nxt(t);
         pv = get_prv(t);
         if (nx != NONE) put_prv(nx, pv);
         else tail[q] = pv;
         if (pv != NONE) put_nxt(pv, nx);
         else head[q] = nx;
         put_nxt(t, NONE);
         put_prv(t, NONE);
         return 1'b1;
      endfunction

      // apply one accepted word and queue the outcome it owes
      function void note_word(mqll_op_type op, logic [QW-1:0] q, logic [TW-1:0] t);
         outcome_type o;
         bit qok;
         o.popped = NONE;
         o.code = RC_DONE;
         qok = q < NUM_QUEUES;
         case (op)
            OP_ENQUEUE: begin
               if (qok) begin
                  link_append(q, {1'b0, t});
                  owner[t] = q;
               end
            end
            OP_DEQUEUE: begin
               if (qok) o.popped = pop_head(q);
               if (o.popped == NONE) o.code = RC_EMPTY;
               else owner[o.popped[TW-1:0]] = -1;
            end
            OP_REMOVE: begin
               if (qok && unlink(q, {1'b0, t})) owner[t] = -1;
               else o.code = RC_ABSENT;
            end
            default: ;
         endcase
         pending_outcomes.push_back(o);
      endfunction

      task check_result(logic [IW-1:0] popped, mqll_code_type code);
         outcome_type want;
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result %0d (popped %0d code %0d) with nothing expected",
                             results_seen, popped, code));
            return;
         end
         want = pending_outcomes.pop_front();
         if (popped !== want.popped)
            report($sformatf("result %0d popped_id %0d, expected %0d",
                             results_seen, popped, want.popped));
         if (code !== want.code)
            report($sformatf("result %0d result_code %0d, expected %0d",
                             results_seen, code, want.code));
         if (!$isunknown(code)) code_hits[code]++;
         if (want.popped != NONE) pops++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mqll_op_type req_opcode = OP_ENQUEUE;
   logic [QW-1:0] req_queue_id = '0;
   logic [TW-1:0] req_thread_id = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [IW-1:0] rsp_popped_id;
   mqll_code_type rsp_result_code;

   linked_queue_checker sb = new();
   bit calm = 1'b0;
   bit hold_done = 1'b0;
   int words_sent = 0;
   int cycle_count = 0;

   multi_queue_linked_list_manager_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_queue_id(req_queue_id),
      .req_thread_id(req_thread_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_popped_id(rsp_popped_id),
      .rsp_result_code(rsp_result_code)
   );

   always #5 clock = ~clock;

   // offer one word and hold it until taken
   task automatic send_word(mqll_op_type op, logic [QW-1:0] q, logic [TW-1:0] t);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_queue_id <= q;
      req_thread_id <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_word(op, q, t);
      words_sent++;
   endtask

   // random sender gap between words
   task automatic sender_pause();
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic put(mqll_op_type op, logic [QW-1:0] q, logic [TW-1:0] t);
      sender_pause();
      send_word(op, q, t);
   endtask

   // mostly a few busy queues so lists grow long, sometimes any or out of range
   function automatic logic [QW-1:0] pick_queue();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return QW'($urandom_range(0, 3));
      if (r < 75) return QW'(NUM_QUEUES - 1);
      if (r < 95) return QW'($urandom_range(0, NUM_QUEUES - 1));
      return QW'($urandom_range(NUM_QUEUES, 2**QW - 1));
   endfunction

   // thread whose tracked queue matches, -1 when there is none
   function automatic int find_thread(int wanted);
      int start;
      int k;
      int idx;
      start = $urandom_range(0, NUM_THREADS - 1);
      for (k = 0; k < NUM_THREADS; k++) begin
         idx = (start + k) % NUM_THREADS;
         if (sb.owner[idx] == wanted) return idx;
      end
      return -1;
   endfunction

   // result side: random stalls, one long hold-off once the block is busy
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_popped_id, rsp_result_code);
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      mqll_op_type op;
      logic [QW-1:0] q;
      logic [TW-1:0] t;
      int r;
      int found;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, extremes, out of range, unused opcode
      put(OP_DEQUEUE, 7'd0, 6'd0);
      put(OP_ENQUEUE, 7'd0, 6'd0);
      put(OP_ENQUEUE, 7'd0, 6'd63);
      put(OP_ENQUEUE, 7'd64, 6'd5);
      put(OP_DEQUEUE, 7'd0, 6'd63);
      put(OP_REMOVE, 7'd0, 6'd63);
      put(OP_REMOVE, 7'd0, 6'd63);
      put(OP_ENQUEUE, 7'd127, 6'd10);
      put(OP_DEQUEUE, 7'd65, 6'd0);
      put(OP_REMOVE, 7'd100, 6'd10);
      put(OP_UNUSED, 7'd3, 6'd42);
      // remove from middle, head and tail, then a thread not in the queue
      put(OP_ENQUEUE, 7'd1, 6'd1);
      put(OP_ENQUEUE, 7'd1, 6'd2);
      put(OP_ENQUEUE, 7'd1, 6'd3);
      put(OP_ENQUEUE, 7'd1, 6'd4);
      put(OP_REMOVE, 7'd1, 6'd3);
      put(OP_REMOVE, 7'd1, 6'd1);
      put(OP_REMOVE, 7'd1, 6'd4);
      put(OP_REMOVE, 7'd1, 6'd9);
      put(OP_DEQUEUE, 7'd1, 6'd0);
      put(OP_DEQUEUE, 7'd64, 6'd0);
      // same thread enqueued twice, then single element dequeue
      put(OP_ENQUEUE, 7'd2, 6'd7);
      put(OP_ENQUEUE, 7'd2, 6'd7);
      put(OP_DEQUEUE, 7'd2, 6'd0);
      put(OP_DEQUEUE, 7'd2, 6'd0);

      // random: mostly well-formed traffic, rare double enqueue and junk
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         r = $urandom_range(0, 99);
         q = pick_queue();
         t = TW'($urandom);
         if (r < 42) begin
            op = OP_ENQUEUE;
            found = find_thread(-1);
            if (found < 0) op = OP_DEQUEUE;
            else if ($urandom_range(0, 99) != 0) t = TW'(found);
         end else if (r < 72) begin
            op = OP_DEQUEUE;
         end else if (r < 97) begin
            op = OP_REMOVE;
            found = find_thread(q);
            if (found >= 0 && $urandom_range(0, 3) != 0) t = TW'(found);
         end else begin
            op = OP_UNUSED;
         end
         put(op, q, t);
      end
      req_valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (sb.pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_outcomes.size() != 0)
         sb.report($sformatf("%0d outcomes never arrived", sb.pending_outcomes.size()));

      $display("tb: %0d words sent, %0d results checked, %0d threads popped",
               words_sent, sb.results_seen, sb.pops);
      $display("tb: done %0d, empty dequeue %0d, absent remove %0d, result hold %0d cycles",
               sb.code_hits[RC_DONE], sb.code_hits[RC_EMPTY], sb.code_hits[RC_ABSENT],
               hold_done ? HOLD_CYCLES : 0);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
